### sv/bmasc_pkg.sv
package bmasc_pkg;

    localparam int MAX_DIGITS = 16;
    localparam int DIGIT_W    = 4;
    localparam int WORD_W     = MAX_DIGITS * DIGIT_W;
    localparam int LEN_W      = 5;

    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_CMP = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD      = 2'd1;
    localparam logic [1:0] ST_NEGATIVE = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // what one digit lane finds
    typedef struct packed {
        logic                 bad;
        logic [DIGIT_W:0]     sum_raw;
        logic                 gen_add;
        logic                 prop_add;
        logic [DIGIT_W-1:0]   diff_raw;
        logic                 gen_sub;
        logic                 prop_sub;
    } lane_info_t;

    // merged result of one item
    typedef struct packed {
        logic                 valid;
        logic [WORD_W-1:0]    digits;
        logic                 less;
        logic                 equal;
        logic [1:0]           status;
    } merge_out_t;

endpackage

### sv/bmasc_lane.sv
module bmasc_lane
(
    input  logic                        clk,
    input  logic [3:0]                  first_digit,
    input  logic [3:0]                  second_digit,
    output bmasc_pkg::lane_info_t       info
);
    import bmasc_pkg::*;

    lane_info_t info_reg;
    lane_info_t info_next;
    logic [DIGIT_W:0] a_ext;
    logic [DIGIT_W:0] b_ext;
    logic [DIGIT_W:0] diff_ext;

    always_comb
    begin
        a_ext              = {1'b0, first_digit};
        b_ext              = {1'b0, second_digit};
        info_next.bad      = (first_digit > 4'd9) || (second_digit > 4'd9);
        info_next.sum_raw  = a_ext + b_ext;
        info_next.gen_add  = info_next.sum_raw >= 5'd10;
        info_next.prop_add = info_next.sum_raw == 5'd9;
        info_next.gen_sub  = first_digit < second_digit;
        info_next.prop_sub = first_digit == second_digit;
        // digit difference with a borrow of ten already lent when needed
        if (info_next.gen_sub)
        begin
            diff_ext = a_ext + 5'd10 - b_ext;
        end
        else
        begin
            diff_ext = a_ext - b_ext;
        end
        info_next.diff_raw = diff_ext[DIGIT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        info_reg <= info_next;
    end

    assign info = info_reg;

endmodule

### sv/bmasc_merge.sv
module bmasc_merge
#(
    parameter int NUM_DIGITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid,
    input  logic [1:0]                  operation,
    input  bmasc_pkg::lane_info_t       lanes [NUM_DIGITS],
    output bmasc_pkg::merge_out_t       result
);
    import bmasc_pkg::*;

    localparam int LEVELS = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    logic [LEVELS:0][NUM_DIGITS-1:0] ga;
    logic [LEVELS:0][NUM_DIGITS-1:0] pa;
    logic [LEVELS:0][NUM_DIGITS-1:0] gs;
    logic [LEVELS:0][NUM_DIGITS-1:0] ps;
    logic [NUM_DIGITS-1:0]           bad_bits;
    logic                            carry_in;
    logic                            borrow_in;
    logic [DIGIT_W:0]                sum_c;
    logic [DIGIT_W-1:0]              diff_d;
    logic [WORD_W-1:0]               add_word;
    logic [WORD_W-1:0]               sub_word;
    logic                            any_bad;
    logic                            carry_out;
    logic                            less;
    logic                            equal;

    merge_out_t result_reg;
    merge_out_t result_next;

    // carry and borrow lookahead over the lanes
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            ga[0][i]    = lanes[i].gen_add;
            pa[0][i]    = lanes[i].prop_add;
            gs[0][i]    = lanes[i].gen_sub;
            ps[0][i]    = lanes[i].prop_sub;
            bad_bits[i] = lanes[i].bad;
        end
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                if (i >= (1 << l))
                begin
                    ga[l+1][i] = ga[l][i] | (pa[l][i] & ga[l][i - (1 << l)]);
                    pa[l+1][i] = pa[l][i] & pa[l][i - (1 << l)];
                    gs[l+1][i] = gs[l][i] | (ps[l][i] & gs[l][i - (1 << l)]);
                    ps[l+1][i] = ps[l][i] & ps[l][i - (1 << l)];
                end
                else
                begin
                    ga[l+1][i] = ga[l][i];
                    pa[l+1][i] = pa[l][i];
                    gs[l+1][i] = gs[l][i];
                    ps[l+1][i] = ps[l][i];
                end
            end
        end
    end

    // final digit correction per lane
    always_comb
    begin
        add_word = '0;
        sub_word = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            carry_in  = (i == 0) ? 1'b0 : ga[LEVELS][(i == 0) ? 0 : i - 1];
            borrow_in = (i == 0) ? 1'b0 : gs[LEVELS][(i == 0) ? 0 : i - 1];
            sum_c = lanes[i].sum_raw + {{DIGIT_W{1'b0}}, carry_in};
            if (sum_c >= 5'd10)
            begin
                sum_c = sum_c - 5'd10;
            end
            if (borrow_in && (lanes[i].diff_raw == 4'd0))
            begin
                diff_d = 4'd9;
            end
            else
            begin
                diff_d = lanes[i].diff_raw - {{(DIGIT_W-1){1'b0}}, borrow_in};
            end
            add_word[DIGIT_W*i +: DIGIT_W] = sum_c[DIGIT_W-1:0];
            sub_word[DIGIT_W*i +: DIGIT_W] = diff_d;
        end
    end

    always_comb
    begin
        any_bad   = |bad_bits;
        carry_out = ga[LEVELS][NUM_DIGITS-1];
        // a borrow out of the full difference means first is below second
        less      = gs[LEVELS][NUM_DIGITS-1];
        equal     = &ps[0];

        result_next.valid  = valid;
        result_next.digits = '0;
        result_next.less   = less;
        result_next.equal  = equal;
        result_next.status = ST_OK;
        priority if (any_bad)
        begin
            result_next.less   = 1'b0;
            result_next.equal  = 1'b0;
            result_next.status = ST_BAD;
        end
        else if (operation == OP_ADD)
        begin
            if (carry_out)
            begin
                result_next.status = ST_OVERFLOW;
            end
            else
            begin
                result_next.digits = add_word;
            end
        end
        else if (operation == OP_SUB)
        begin
            if (less)
            begin
                result_next.status = ST_NEGATIVE;
            end
            else
            begin
                result_next.digits = sub_word;
            end
        end
        else
        begin
            // compare only, and the unused code behaves the same
            result_next.status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### sv/bcd_money_add_sub_compare_unit.sv
// decimal money add, subtract and compare on packed bcd operands
// input channel: raise start with operation, first_digits and second_digits;
//   the item is taken at the rising edge where start is high and busy is low.
//   busy is always low, so a new item can be taken every cycle.
// output channel: done is high for exactly one cycle with result_digits,
//   result_length, first_less, operands_equal and status; the receiver
//   must take the item in that cycle, it cannot hold results off.
// pipeline: an item taken at an edge passes three register stages (digit
//   lanes, lookahead merge, length encode) before its result shows with done.
// throughput: one item per cycle, the stages are fully pipelined.
// digits 0 and 1 are the cents; only the low NUM_DIGITS nibbles are used,
//   higher result nibbles read as zero.
// reset: rst_n clears the valid pipeline so no done pulse follows reset;
//   items in flight at reset are dropped.
module bcd_money_add_sub_compare_unit
#(
    parameter int NUM_DIGITS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         operation,
    input  logic [bmasc_pkg::WORD_W-1:0]       first_digits,
    input  logic [bmasc_pkg::WORD_W-1:0]       second_digits,
    output logic                               done,
    output logic [bmasc_pkg::WORD_W-1:0]       result_digits,
    output logic [bmasc_pkg::LEN_W-1:0]        result_length,
    output logic                               first_less,
    output logic                               operands_equal,
    output logic [1:0]                         status
);
    import bmasc_pkg::*;

    // stage 1: one lane per digit, lanes register their own findings
    lane_info_t lanes [NUM_DIGITS];
    logic       s1_valid_reg;
    logic [1:0] s1_op_reg;

    // stage 2: merge of the lanes
    merge_out_t merged;

    // stage 3: length encode and output registers
    logic                done_reg;
    logic [WORD_W-1:0]   digits_reg;
    logic [LEN_W-1:0]    length_reg;
    logic [LEN_W-1:0]    length_next;
    logic                less_reg;
    logic                equal_reg;
    logic [1:0]          status_reg;

    // never stalls
    assign busy = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_DIGITS; gi++)
        begin : g_lane
            bmasc_lane u_lane
            (
                .clk          (clk),
                .first_digit  (first_digits[DIGIT_W*gi +: DIGIT_W]),
                .second_digit (second_digits[DIGIT_W*gi +: DIGIT_W]),
                .info         (lanes[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg <= operation;
    end

    bmasc_merge
    #(
        .NUM_DIGITS (NUM_DIGITS)
    )
    u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (s1_valid_reg),
        .operation (s1_op_reg),
        .lanes     (lanes),
        .result    (merged)
    );

    // highest nonzero digit plus one, zero for a zero value
    always_comb
    begin
        length_next = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (merged.digits[DIGIT_W*i +: DIGIT_W] != 4'd0)
            begin
                length_next = LEN_W'(i + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= merged.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= merged.digits;
        length_reg <= length_next;
        less_reg   <= merged.less;
        equal_reg  <= merged.equal;
        status_reg <= merged.status;
    end

    assign done           = done_reg;
    assign result_digits  = digits_reg;
    assign result_length  = length_reg;
    assign first_less     = less_reg;
    assign operands_equal = equal_reg;
    assign status         = status_reg;

    // every taken item comes out with done after the three register stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##3 done)
        else $error("item did not complete in three cycles");

    // a bad digit clears the whole result
    a_bad_clears: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_BAD) |->
            (result_digits == '0) && (result_length == '0) &&
            !first_less && !operands_equal)
        else $error("bad digit result not cleared");

    // errors give no digits
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && ((status == ST_NEGATIVE) || (status == ST_OVERFLOW)) |->
            (result_digits == '0) && (result_length == '0))
        else $error("error result carries digits");

    // length and digits agree on zero
    a_length_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result_digits == '0) == (result_length == '0)))
        else $error("length disagrees with digits");

    // comparison flags exclude each other, negative needs less
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(first_less && operands_equal) &&
            ((status != ST_NEGATIVE) || first_less))
        else $error("inconsistent comparison flags");

endmodule
